@@ hdl/hsv_color_wheel_grb_packer_assert.svh @@
// Assertion macros shared by the checker of the colour wheel packer.
// Depends on nothing; the including file supplies clock, reset and properties.
`ifndef HSV_COLOR_WHEEL_GRB_PACKER_ASSERT_SVH
`define HSV_COLOR_WHEEL_GRB_PACKER_ASSERT_SVH

// Clocked check that is ignored while the synchronous reset is held.
`define HCWP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define HCWP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/hcwp_pkg.sv @@
// Types, wheel mode codes and helpers for the colour wheel packer.
// Used by every module of the block; depends on nothing.
package hcwp_pkg;

    localparam logic [2:0] MODE_FULL = 3'd0;
    localparam logic [2:0] MODE_RG   = 3'd1;
    localparam logic [2:0] MODE_GB   = 3'd2;
    localparam logic [2:0] MODE_BR   = 3'd3;
    localparam logic [2:0] MODE_TRI  = 3'd4;

    localparam logic [7:0] BYTE_FULL  = 8'hff;
    localparam logic [7:0] BYTE_TOP   = 8'h80;
    localparam logic [7:0] TRI_TOP    = 8'd127;
    // Adding a multiple of three keeps the residue but makes the hue quotient positive.
    localparam logic [7:0] HUE_Q_BIAS = 8'd66;

    typedef struct packed {
        logic [2:0]         wheel_mode;
        logic [15:0]        pixel_index;
        logic signed [15:0] hue;
        logic [15:0]        wheel_position;
        logic [7:0]         value_level;
        logic [7:0]         saturation;
    } t_request;

    typedef struct packed {
        logic [15:0] target_pixel;
        logic        write_enable;
        logic [7:0]  green_byte;
        logic [7:0]  red_byte;
        logic [7:0]  blue_byte;
    } t_result;

    // Base colour of one pixel before saturation and value are applied.
    typedef struct packed {
        logic [15:0] target_pixel;
        logic        write_enable;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  value_level;
        logic [7:0]  saturation;
    } t_colour;

    // Residue modulo three; powers of four are one modulo three, so the
    // base-four digits are summed and the small sum is folded twice.
    function automatic logic [1:0] mod3_10(input logic [9:0] x);
        logic [3:0] s;
        logic [2:0] s2;
        logic [2:0] r;
        s  = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]) + 4'(x[9:8]);
        s2 = 3'(s[3:2]) + 3'(s[1:0]);
        if (s2 >= 3'd6) begin
            r = s2 - 3'd6;
        end else if (s2 >= 3'd3) begin
            r = s2 - 3'd3;
        end else begin
            r = s2;
        end
        return r[1:0];
    endfunction

endpackage

@@ hdl/hcwp_wheel.sv @@
// Front half of the pipeline: wheel reduction, strip check and base colour.
// Depends on hcwp_pkg.
module hcwp_wheel
    import hcwp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_request    i_request,
    input  logic [15:0] i_strip_length,
    output logic        o_valid,
    output t_colour     o_colour
);

    logic        r_a_valid;
    logic [15:0] r_a_pixel;
    logic        r_a_we;
    logic [2:0]  r_a_mode;
    logic [2:0]  r_a_seg;
    logic [7:0]  r_a_lo;
    logic [7:0]  r_a_v;
    logic [7:0]  r_a_s;

    logic [7:0]  n_hue_q;
    logic [1:0]  n_hue_q3;
    logic [1:0]  n_pos_q3;
    logic [2:0]  n_seg;
    logic [7:0]  n_lo;

    logic        r_b_valid;
    t_colour     r_b_colour;
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;
    logic [7:0]  n_first;
    logic [7:0]  n_second;
    logic [7:0]  n_tri_lo;

    // 1536 and 384 are three times a power of two, so only the quotient
    // above the low bits needs a residue modulo three.
    always_comb begin
        n_hue_q  = {i_request.hue[15], i_request.hue[15:9]} + HUE_Q_BIAS;
        n_hue_q3 = mod3_10({2'b00, n_hue_q});
        n_pos_q3 = mod3_10({1'b0, i_request.wheel_position[15:7]});
        n_seg    = 3'd0;
        n_lo     = i_request.hue[7:0];
        case (i_request.wheel_mode) inside
            MODE_FULL: n_seg = {n_hue_q3, i_request.hue[8]};
            MODE_RG, MODE_GB, MODE_BR: n_seg = {1'b0, i_request.hue[9:8]};
            MODE_TRI: begin
                n_seg = {1'b0, n_pos_q3};
                n_lo  = {1'b0, i_request.wheel_position[6:0]};
            end
            default: n_seg = 3'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_pixel <= i_request.pixel_index;
        r_a_we    <= (i_request.pixel_index < i_strip_length);
        r_a_mode  <= i_request.wheel_mode;
        r_a_seg   <= n_seg;
        r_a_lo    <= n_lo;
        r_a_v     <= i_request.value_level;
        r_a_s     <= i_request.saturation;
    end

    always_comb begin
        n_red    = 8'd0;
        n_green  = 8'd0;
        n_blue   = 8'd0;
        n_tri_lo = TRI_TOP - r_a_lo;
        // Lines run first primary full, fade in the second, fade out the first, back.
        case (r_a_seg[1:0])
            2'd0:    begin n_first = BYTE_FULL;          n_second = r_a_lo;             end
            2'd1:    begin n_first = BYTE_FULL - r_a_lo; n_second = BYTE_FULL;          end
            2'd2:    begin n_first = r_a_lo;             n_second = BYTE_FULL;          end
            default: begin n_first = BYTE_FULL;          n_second = BYTE_FULL - r_a_lo; end
        endcase
        case (r_a_mode)
            MODE_FULL: begin
                case (r_a_seg)
                    3'd0: begin n_red = BYTE_FULL; n_green = r_a_lo; end
                    3'd1: begin n_red = BYTE_FULL - r_a_lo; n_green = BYTE_FULL; end
                    3'd2: begin n_green = BYTE_FULL; n_blue = r_a_lo; end
                    3'd3: begin n_green = BYTE_FULL - r_a_lo; n_blue = BYTE_FULL; end
                    3'd4: begin n_red = r_a_lo; n_blue = BYTE_FULL; end
                    default: begin n_red = BYTE_FULL; n_blue = BYTE_FULL - r_a_lo; end
                endcase
            end
            MODE_RG: begin n_red = n_first; n_green = n_second; end
            MODE_GB: begin n_green = n_first; n_blue = n_second; end
            MODE_BR: begin n_blue = n_first; n_red = n_second; end
            MODE_TRI: begin
                case (r_a_seg)
                    3'd0:    begin n_red = n_tri_lo; n_green = r_a_lo; end
                    3'd1:    begin n_green = n_tri_lo; n_blue = r_a_lo; end
                    default: begin n_blue = n_tri_lo; n_red = r_a_lo; end
                endcase
            end
            default: begin
                n_red = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_colour.target_pixel <= r_a_pixel;
        r_b_colour.write_enable <= r_a_we;
        r_b_colour.red          <= n_red;
        r_b_colour.green        <= n_green;
        r_b_colour.blue         <= n_blue;
        r_b_colour.value_level  <= r_a_v;
        r_b_colour.saturation   <= r_a_s;
    end

    assign o_valid  = r_b_valid;
    assign o_colour = r_b_colour;

endmodule

@@ hdl/hcwp_shade.sv @@
// Back half of the pipeline: saturation then value on each channel, strip bytes.
// Depends on hcwp_pkg.
module hcwp_shade
    import hcwp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_colour i_colour,
    output logic    o_valid,
    output t_result o_result
);

    logic [7:0]  w_chan [3];
    logic [8:0]  w_s1;
    logic [8:0]  w_v1;
    logic [16:0] n_desat [3];
    logic [7:0]  n_sat [3];

    logic        r_c_valid;
    logic [7:0]  r_c_chan [3];
    logic [7:0]  r_c_v1;
    logic [15:0] r_c_pixel;
    logic        r_c_we;

    logic [16:0] n_lit [3];

    logic        r_d_valid;
    t_result     r_d_result;

    assign w_chan[0] = i_colour.green;
    assign w_chan[1] = i_colour.red;
    assign w_chan[2] = i_colour.blue;
    assign w_s1      = {1'b0, i_colour.saturation} + 9'd1;
    assign w_v1      = {1'b0, r_c_v1} + 9'd1;

    // The distance to white is scaled down, so low saturation pulls towards white.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_desat[k] = 17'(BYTE_FULL - w_chan[k]) * 17'(w_s1);
            n_sat[k]   = BYTE_FULL - n_desat[k][15:8];
            n_lit[k]   = 17'(r_c_chan[k]) * 17'(w_v1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_c_valid <= i_valid;
            r_d_valid <= r_c_valid;
        end
        for (int k = 0; k < 3; k++) begin
            r_c_chan[k] <= n_sat[k];
        end
        r_c_v1    <= i_colour.value_level;
        r_c_pixel <= i_colour.target_pixel;
        r_c_we    <= i_colour.write_enable;
        r_d_result.target_pixel <= r_c_pixel;
        r_d_result.write_enable <= r_c_we;
        r_d_result.green_byte   <= n_lit[0][15:8] | BYTE_TOP;
        r_d_result.red_byte     <= n_lit[1][15:8] | BYTE_TOP;
        r_d_result.blue_byte    <= n_lit[2][15:8] | BYTE_TOP;
    end

    assign o_valid  = r_d_valid;
    assign o_result = r_d_result;

endmodule

@@ hdl/hsv_color_wheel_grb_packer.sv @@
// Top level of the HSV colour wheel packer for a GRB strip with 7-bit channels.
// Depends on hcwp_pkg, hcwp_wheel and hcwp_shade.
//
// A request is taken on every clock edge at which start is high and busy is low;
// busy is high only while reset is held, so one pixel per clock is sustained.
// Each request leaves as one result, marked by o_strobe for a single cycle, once
// it has passed the four register stages (wheel reduction, base colour, saturation
// multiply, value multiply). The receiver cannot stall the results, so it must
// take every strobe. strip_length is written through i_cfg_we and i_cfg_data and
// should only change while no request is in flight.
module hsv_color_wheel_grb_packer
    import hcwp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_request    i_request,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output t_result     o_result
);

    logic [15:0] r_strip_length;
    logic        w_accept;
    logic        w_colour_valid;
    t_colour     w_colour;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_length <= 16'd0;
        end else if (i_cfg_we) begin
            r_strip_length <= i_cfg_data;
        end
    end

    hcwp_wheel u_wheel (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_accept),
        .i_request      (i_request),
        .i_strip_length (r_strip_length),
        .o_valid        (w_colour_valid),
        .o_colour       (w_colour)
    );

    hcwp_shade u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_colour_valid),
        .i_colour (w_colour),
        .o_valid  (o_strobe),
        .o_result (o_result)
    );

endmodule

@@ hdl/hcwp_checker.sv @@
// Port-level checks of the colour wheel packer, bound to its top level.
// Depends on hcwp_pkg and hsv_color_wheel_grb_packer_assert.svh.
`include "hsv_color_wheel_grb_packer_assert.svh"

module hcwp_checker
    import hcwp_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_request i_request,
    input logic     o_strobe,
    input t_result  o_result
);

    property p_request_gives_result;
        (start && !busy) |-> ##4 o_strobe;
    endproperty

    property p_result_has_request;
        o_strobe |-> $past(start && !busy, 4);
    endproperty

    property p_pixel_passes;
        o_strobe |-> (o_result.target_pixel == $past(i_request.pixel_index, 4));
    endproperty

    property p_top_bits_set;
        o_strobe |-> (o_result.green_byte[7] && o_result.red_byte[7] && o_result.blue_byte[7]);
    endproperty

    // Outside reset the block never refuses a request.
    `HCWP_ASSERT_ALWAYS(a_busy_only_in_reset, i_clk, i_rst_n |-> !busy, "busy outside reset")

    `HCWP_ASSERT(a_request_gives_result, i_clk, i_rst_n, p_request_gives_result, "request lost")

    `HCWP_ASSERT(a_result_has_request, i_clk, i_rst_n, p_result_has_request, "stray result")

    `HCWP_ASSERT(a_pixel_passes, i_clk, i_rst_n, p_pixel_passes, "pixel index changed")

    `HCWP_ASSERT(a_top_bits_set, i_clk, i_rst_n, p_top_bits_set, "strip byte without top bit")

endmodule

bind hsv_color_wheel_grb_packer hcwp_checker u_hcwp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_request (i_request),
    .o_strobe  (o_strobe),
    .o_result  (o_result)
);
